/* rtl/core/idsc_pkg.sv */
`timescale 1ns / 1ps

package idsc_pkg;

   localparam int MeasWidth   = 16;
   localparam int DtWidth     = 16;
   localparam int CmdWidth    = 12;
   localparam int TargetWidth = 12;
   localparam int GainWidth   = 20;
   localparam int BandWidth   = 10;
   localparam int LimitWidth  = 31;
   localparam int IntegWidth  = 32;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 31;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TARGET       = 3'd0,
      CSR_FEEDFORWARD  = 3'd1,
      CSR_GAIN         = 3'd2,
      CSR_DEADBAND_ON  = 3'd3,
      CSR_DEADBAND_OFF = 3'd4,
      CSR_LIMIT        = 3'd5,
      CSR_CMD_MAX      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TargetWidth-1:0] target_diameter_um;
      logic [CmdWidth-1:0]    feedforward_steps;
      logic [GainWidth-1:0]   integral_gain_q32;
      logic [BandWidth-1:0]   deadband_on_um;
      logic [BandWidth-1:0]   deadband_off_um;
      logic [LimitWidth-1:0]  integral_limit;
      logic [CmdWidth-1:0]    command_max;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic do_err;
      logic do_sum;
      logic do_mul;
      logic load_out;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ERR  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

/* rtl/core/idsc_if.sv */
`timescale 1ns / 1ps

interface idsc_req_if
   import idsc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [MeasWidth-1:0] measured_diameter_um;
   logic                        sensor_valid;
   logic                        motor_running;
   logic [DtWidth-1:0]          elapsed_ms;
   logic                        restart;

   modport source (output valid, output measured_diameter_um, output sensor_valid,
                   output motor_running, output elapsed_ms, output restart,
                   input ready);
   modport sink (input valid, input measured_diameter_um, input sensor_valid,
                 input motor_running, input elapsed_ms, input restart,
                 output ready);
endinterface

interface idsc_rsp_if
   import idsc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CmdWidth-1:0] command_steps;
   logic                control_active;
   logic                holding;

   modport source (output valid, output command_steps, output control_active,
                   output holding, input ready);
   modport sink (input valid, input command_steps, input control_active,
                 input holding, output ready);
endinterface

/* rtl/core/idsc_csr.sv */
`timescale 1ns / 1ps

module idsc_csr
   import idsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET:       cfg_in.target_diameter_um = csr_wdata[TargetWidth-1:0];
            CSR_FEEDFORWARD:  cfg_in.feedforward_steps  = csr_wdata[CmdWidth-1:0];
            CSR_GAIN:         cfg_in.integral_gain_q32  = csr_wdata[GainWidth-1:0];
            CSR_DEADBAND_ON:  cfg_in.deadband_on_um     = csr_wdata[BandWidth-1:0];
            CSR_DEADBAND_OFF: cfg_in.deadband_off_um    = csr_wdata[BandWidth-1:0];
            CSR_LIMIT:        cfg_in.integral_limit     = csr_wdata[LimitWidth-1:0];
            CSR_CMD_MAX:      cfg_in.command_max        = csr_wdata[CmdWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_diameter_um <= 12'd1750;
         cfg_ff.feedforward_steps  <= 12'd978;
         cfg_ff.integral_gain_q32  <= 20'd34360;
         cfg_ff.deadband_on_um     <= 10'd60;
         cfg_ff.deadband_off_um    <= 10'd40;
         cfg_ff.integral_limit     <= 31'd1000000000;
         cfg_ff.command_max        <= 12'd3000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/idsc_ctrl.sv */
`timescale 1ns / 1ps

module idsc_ctrl
   import idsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.do_err = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // The result register is free once its previous transfer completes.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/idsc_datapath.sv */
`timescale 1ns / 1ps

module idsc_datapath
   import idsc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  cmd_type                     cmd,
   input  logic signed [MeasWidth-1:0] measured_diameter_um,
   input  logic                        sensor_valid,
   input  logic                        motor_running,
   input  logic [DtWidth-1:0]          elapsed_ms,
   input  logic                        restart,
   output logic [CmdWidth-1:0]         command_steps,
   output logic                        control_active,
   output logic                        holding
);

   // Captured item.
   logic signed [MeasWidth-1:0] meas_ff;
   logic [DtWidth-1:0]          dt_ff;
   logic                        ok_ff;
   logic                        restart_ff;

   // Controller state.
   logic signed [IntegWidth-1:0] integ_ff, integ_in;
   logic                         active_ff, active_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [CmdWidth-1:0]          hold_cmd_ff, hold_cmd_in;

   // Intermediate results.
   logic signed [33:0]  prod_ff;
   logic [51:0]         gprod_ff;
   logic                neg_ff;

   // Result register.
   logic [CmdWidth-1:0] out_cmd_ff;
   logic                out_active_ff;
   logic                out_holding_ff;

   logic signed [16:0] err;
   logic [16:0]        aerr;
   logic               act_on;
   logic               act_next;
   logic signed [33:0] prod;
   logic signed [34:0] sum;
   logic signed [34:0] lim_pos;
   logic signed [34:0] lim_neg;
   logic [31:0]        mag;
   logic [52:0]        rnd;
   logic [20:0]        rmag;
   logic signed [22:0] pid_sum;
   logic [CmdWidth-1:0] pid_cmd;
   logic [CmdWidth-1:0] hold_clamped;
   logic [CmdWidth-1:0] ff_clamped;
   logic [CmdWidth-1:0] cmd_sel;
   logic                holding_sel;

   assign err  = 17'(meas_ff) - $signed({5'b0, cfg.target_diameter_um});
   assign aerr = err[16] ? 17'(-err) : 17'(err);

   // Switch-on test first, then switch-off test, in the same tick.
   assign act_on   = active_ff || (aerr >= {7'b0, cfg.deadband_on_um});
   assign act_next = act_on && !(aerr <= {7'b0, cfg.deadband_off_um});

   assign prod = 34'(err) * 34'($signed({1'b0, dt_ff}));

   assign sum     = 35'(integ_ff) + 35'(prod_ff);
   assign lim_pos = $signed({4'b0, cfg.integral_limit});
   assign lim_neg = -lim_pos;

   assign mag = integ_ff[IntegWidth-1] ? 32'(-integ_ff) : 32'(integ_ff);

   // Round the Q32 product half away from zero on its magnitude.
   assign rnd     = {1'b0, gprod_ff} + 53'h0_0000_8000_0000;
   assign rmag    = rnd[52:32];
   assign pid_sum = neg_ff ? ($signed({11'b0, cfg.feedforward_steps}) - $signed({2'b0, rmag}))
                           : ($signed({11'b0, cfg.feedforward_steps}) + $signed({2'b0, rmag}));

   always_comb begin
      if (pid_sum[22]) begin
         pid_cmd = '0;
      end else if (pid_sum > $signed({11'b0, cfg.command_max})) begin
         pid_cmd = cfg.command_max;
      end else begin
         pid_cmd = pid_sum[CmdWidth-1:0];
      end
   end

   assign hold_clamped = (hold_cmd_ff > cfg.command_max) ? cfg.command_max : hold_cmd_ff;
   assign ff_clamped   = (cfg.feedforward_steps > cfg.command_max) ? cfg.command_max
                                                                    : cfg.feedforward_steps;

   always_comb begin
      integ_in      = integ_ff;
      active_in     = active_ff;
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      cmd_sel       = '0;
      holding_sel   = 1'b0;

      if (cmd.do_err) begin
         if (restart_ff || !ok_ff) begin
            integ_in      = '0;
            hold_valid_in = 1'b0;
            hold_cmd_in   = '0;
         end
         active_in = ok_ff && act_next;
      end

      if (cmd.do_sum && ok_ff && active_ff) begin
         if (sum > lim_pos) begin
            integ_in = 32'(lim_pos);
         end else if (sum < lim_neg) begin
            integ_in = 32'(lim_neg);
         end else begin
            integ_in = 32'(sum);
         end
      end

      priority if (!ok_ff) begin
         cmd_sel = '0;
      end else if (active_ff) begin
         cmd_sel = pid_cmd;
      end else if (hold_valid_ff) begin
         cmd_sel     = hold_clamped;
         holding_sel = 1'b1;
      end else begin
         cmd_sel = ff_clamped;
      end

      // A fresh command becomes the held command.
      if (cmd.load_out && ok_ff && !holding_sel) begin
         hold_cmd_in   = cmd_sel;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         active_ff     <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_cmd_ff   <= '0;
      end else begin
         integ_ff      <= integ_in;
         active_ff     <= active_in;
         hold_valid_ff <= hold_valid_in;
         hold_cmd_ff   <= hold_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         meas_ff    <= measured_diameter_um;
         dt_ff      <= elapsed_ms;
         ok_ff      <= sensor_valid && motor_running;
         restart_ff <= restart;
      end
      if (cmd.do_err) begin
         prod_ff <= prod;
      end
      if (cmd.do_mul) begin
         gprod_ff <= 52'(mag) * 52'(cfg.integral_gain_q32);
         neg_ff   <= integ_ff[IntegWidth-1];
      end
      if (cmd.load_out) begin
         out_cmd_ff     <= cmd_sel;
         out_active_ff  <= ok_ff && active_ff;
         out_holding_ff <= holding_sel;
      end
   end

   assign command_steps  = out_cmd_ff;
   assign control_active = out_active_ff;
   assign holding        = out_holding_ff;

endmodule

/* rtl/core/integral_deadband_speed_control.sv */
`timescale 1ns / 1ps
// A result is registered after its input transfer passes through the
// four-step sequence error/product, integral clamp, gain multiply, output.
// One item is taken at a time: the input is ready only in the idle step,
// while a finished result may still wait in the output register.
// Reset (synchronous, active high) clears the integral, the hysteresis and
// hold state and loads the configuration registers with their defaults.

module integral_deadband_speed_control
   import idsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   idsc_req_if.sink                req_chan,
   idsc_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;

   idsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   idsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   idsc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .measured_diameter_um (req_chan.measured_diameter_um),
      .sensor_valid         (req_chan.sensor_valid),
      .motor_running        (req_chan.motor_running),
      .elapsed_ms           (req_chan.elapsed_ms),
      .restart              (req_chan.restart),
      .command_steps        (rsp_chan.command_steps),
      .control_active       (rsp_chan.control_active),
      .holding              (rsp_chan.holding)
   );

endmodule

/* rtl/core/idsc_checker.sv */
`timescale 1ns / 1ps

module idsc_checker
   import idsc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [CmdWidth-1:0] command_steps,
   input logic                control_active,
   input logic                holding
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result may only be offered for an item that was taken in.
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("result offered with no item outstanding");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("input ready right after a transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(command_steps) && $stable(control_active)
          && $stable(holding)))
      else $error("stalled result changed");

   // A held command is only shown while integral control is off.
   a_holding_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && holding) |-> !control_active)
      else $error("holding while control is active");

endmodule

bind integral_deadband_speed_control idsc_checker u_idsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .command_steps  (rsp_chan.command_steps),
   .control_active (rsp_chan.control_active),
   .holding        (rsp_chan.holding)
);
